/* rtl/slns_pkg.sv */
// ----------------------------------------------------------------------------
// slns_pkg
// Shared types and constants of the scan-line neighbour search.
// ----------------------------------------------------------------------------
package slns_pkg;

  localparam int POINT_DEPTH = 4096;
  localparam int COORD_BITS  = 24;
  localparam int LINE_COUNT  = 64;
  localparam int IDX_BITS    = $clog2(POINT_DEPTH);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int LINE_BITS   = 6;
  localparam int THR_BITS    = 40;
  localparam int DIFF_BITS   = 22;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int SUM_BITS    = SQ_BITS + 2;
  localparam int ENTRY_BITS  = 3 * COORD_BITS + LINE_BITS;
  localparam logic [DIFF_BITS-1:0] DIFF_CAP = DIFF_BITS'(1) << (DIFF_BITS - 1);
  localparam logic [THR_BITS-1:0]  THR_RESET = THR_BITS'(26214400);
  localparam logic [LINE_BITS-1:0] SPAN_RESET = LINE_BITS'(2);
  localparam logic [LINE_BITS-1:0] LINE_MAX = LINE_BITS'(LINE_COUNT - 1);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_EDGE   = 2'd2,
    REQ_PLANE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // register index; registers sit on 8-byte boundaries
  localparam logic [0:0] ADDR_THR  = 1'd0;
  localparam logic [0:0] ADDR_SPAN = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTRE,
    S_UP,
    S_DOWN,
    S_RESULT
  } state_t;

endpackage

/* rtl/slns_if.sv */
// ----------------------------------------------------------------------------
// slns_req_if / slns_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface slns_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic signed [slns_pkg::COORD_BITS-1:0] pos_x;
  logic signed [slns_pkg::COORD_BITS-1:0] pos_y;
  logic signed [slns_pkg::COORD_BITS-1:0] pos_z;
  logic [slns_pkg::LINE_BITS-1:0]        line_id;
  logic [slns_pkg::IDX_BITS-1:0]         nearest_index;
  logic [slns_pkg::THR_BITS-1:0]         nearest_sq_dist;
  modport source (output valid, req_type, pos_x, pos_y, pos_z, line_id,
                  nearest_index, nearest_sq_dist, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, line_id,
                nearest_index, nearest_sq_dist, output ready);
endinterface

interface slns_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [slns_pkg::IDX_BITS-1:0] first_index;
  logic [slns_pkg::IDX_BITS-1:0] second_index;
  logic [slns_pkg::IDX_BITS-1:0] third_index;
  modport source (output valid, status, first_index, second_index, third_index,
                  input ready);
  modport sink (input valid, status, first_index, second_index, third_index,
                output ready);
endinterface

/* rtl/slns_ram.sv */
// ----------------------------------------------------------------------------
// slns_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module slns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/slns_dist.sv */
// ----------------------------------------------------------------------------
// slns_dist
// Two-stage squared distance between a stored point and the query point.
// ----------------------------------------------------------------------------
module slns_dist (
  input  logic                                   clk,
  input  logic signed [slns_pkg::COORD_BITS-1:0] ax,
  input  logic signed [slns_pkg::COORD_BITS-1:0] ay,
  input  logic signed [slns_pkg::COORD_BITS-1:0] az,
  input  logic signed [slns_pkg::COORD_BITS-1:0] bx,
  input  logic signed [slns_pkg::COORD_BITS-1:0] by,
  input  logic signed [slns_pkg::COORD_BITS-1:0] bz,
  output logic [slns_pkg::SUM_BITS-1:0]          dist_r
);

  localparam int DB = slns_pkg::DIFF_BITS;
  localparam int SB = slns_pkg::SQ_BITS;
  localparam int EB = slns_pkg::COORD_BITS + 1;

  logic [DB-1:0] dx_r, dy_r, dz_r;
  logic [SB-1:0] sx, sy, sz;

  // Absolute difference, capped
  function automatic logic [DB-1:0] cap_diff(
    input logic signed [slns_pkg::COORD_BITS-1:0] a,
    input logic signed [slns_pkg::COORD_BITS-1:0] b
  );
    logic signed [EB-1:0] d;
    logic [EB-1:0]        m;
    d = EB'(a) - EB'(b);
    m = d[EB-1] ? EB'(-d) : EB'(d);
    if (m > EB'(slns_pkg::DIFF_CAP)) begin
      return slns_pkg::DIFF_CAP;
    end
    return m[DB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    dx_r <= cap_diff(ax, bx);
    dy_r <= cap_diff(ay, by);
    dz_r <= cap_diff(az, bz);
  end

  // Square and sum
  assign sx = dx_r * dx_r;
  assign sy = dy_r * dy_r;
  assign sz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    dist_r <= slns_pkg::SUM_BITS'(sx) + slns_pkg::SUM_BITS'(sy)
            + slns_pkg::SUM_BITS'(sz);
  end

endmodule

/* rtl/scan_line_neighbour_search.sv */
// ----------------------------------------------------------------------------
// scan_line_neighbour_search
// Edge and plane correspondence search over a scan-ordered point store.
// ----------------------------------------------------------------------------
// Clear and append set the result register directly, then wait for the output
// handshake; one request at a time. In a query each stored point walked costs
//   a memory read, a two-stage distance unit and a compare, done serially.
// Reset is synchronous, active low: store emptied (count zero), registers to
//   default threshold 25 m^2 and span 2. Store contents are not cleared.
module scan_line_neighbour_search (
  input  logic                  clk,
  input  logic                  rst_n,
  slns_req_if.sink              in_req,
  slns_res_if.source            out_res,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [63:0]           cfg_pwdata,
  output logic [63:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IB = slns_pkg::IDX_BITS;
  localparam int CB = slns_pkg::CNT_BITS;
  localparam int LB = slns_pkg::LINE_BITS;
  localparam int TB = slns_pkg::THR_BITS;
  localparam int KB = slns_pkg::COORD_BITS;
  localparam int SUB = slns_pkg::SUM_BITS;

  // Configuration registers
  logic [TB-1:0] thr_r;
  logic [LB-1:0] span_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= slns_pkg::THR_RESET;
      span_r <= slns_pkg::SPAN_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[3:3] == slns_pkg::ADDR_THR && cfg_paddr[2:0] == 3'd0) begin
        thr_r <= cfg_pwdata[TB-1:0];
      end else if (cfg_paddr[3:3] == slns_pkg::ADDR_SPAN && cfg_paddr[2:0] == 3'd0) begin
        span_r <= cfg_pwdata[LB-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr[3:3])
      slns_pkg::ADDR_THR:  cfg_prdata = 64'(thr_r);
      slns_pkg::ADDR_SPAN: cfg_prdata = 64'(span_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Control state
  slns_pkg::state_t state_r, state_nxt;
  logic [CB-1:0]    count_r;
  logic [1:0]       req_r;
  logic signed [KB-1:0] qx_r, qy_r, qz_r;
  logic [IB-1:0]    near_r;
  logic [CB-1:0]    j_r;          // walk position
  logic [1:0]       ph_r;         // 0 read, 1 data, 2 dist, 3 compare
  logic signed [LB+1:0] cl_r;
  logic [TB-1:0]    best2_r, best3_r;
  logic             got2_r, got3_r;
  logic [IB-1:0]    ind2_r, ind3_r;
  logic             ovalid_r;
  logic [1:0]       ostat_r;
  logic [IB-1:0]    of_r, os_r, ot_r;
  logic signed [LB+1:0] l_r;
  logic             edge_q;
  logic             in_fire;

  // Store memory
  logic                  ram_we;
  logic [IB-1:0]         ram_addr;
  logic [slns_pkg::ENTRY_BITS-1:0] ram_wdata, ram_rdata;
  logic [LB-1:0]         app_line;

  slns_ram #(.WIDTH(slns_pkg::ENTRY_BITS), .DEPTH(slns_pkg::POINT_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic signed [KB-1:0] sx, sy, sz;
  logic [LB-1:0]        sl;
  assign {sx, sy, sz, sl} = ram_rdata;

  logic [SUB-1:0] cand_dist;
  slns_dist u_dist (
    .clk(clk), .ax(sx), .ay(sy), .az(sz), .bx(qx_r), .by(qy_r), .bz(qz_r),
    .dist_r(cand_dist)
  );

  assign in_req.ready = (state_r == slns_pkg::S_IDLE) && !ovalid_r;
  assign in_fire = in_req.valid && in_req.ready;
  assign edge_q = (req_r == slns_pkg::REQ_EDGE);
  assign app_line = (in_req.line_id > slns_pkg::LINE_MAX) ? slns_pkg::LINE_MAX
                                                          : in_req.line_id;
  assign ram_we = in_fire && in_req.req_type == slns_pkg::REQ_APPEND &&
                  count_r < CB'(slns_pkg::POINT_DEPTH);
  assign ram_wdata = {in_req.pos_x, in_req.pos_y, in_req.pos_z, app_line};

  // Append slot or nearest entry in idle, nearest entry while its line is fetched, else the walk position
  always_comb begin
    if (state_r == slns_pkg::S_IDLE) begin
      ram_addr = ram_we ? count_r[IB-1:0] : in_req.nearest_index;
    end else if (state_r == slns_pkg::S_CENTRE) begin
      ram_addr = near_r;
    end else begin
      ram_addr = j_r[IB-1:0];
    end
  end

  // Walk decisions on the compare phase
  logic signed [LB+1:0] hi, lo;
  logic up_skip, up_stop, dn_skip, dn_stop, to2, up_last, dn_last;
  assign hi = cl_r + (LB+2)'(span_r);
  assign lo = cl_r - (LB+2)'(span_r);
  assign up_skip = edge_q && l_r <= cl_r;
  assign up_stop = !up_skip && l_r > hi;
  assign dn_skip = edge_q && l_r >= cl_r;
  assign dn_stop = !dn_skip && l_r < lo;
  assign up_last = (j_r + 1'b1) >= count_r;
  assign dn_last = (j_r == '0);

  always_comb begin
    if (state_r == slns_pkg::S_UP) begin
      to2 = edge_q || l_r <= cl_r;
    end else begin
      to2 = edge_q || l_r >= cl_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slns_pkg::S_IDLE: begin
        if (in_fire && (in_req.req_type == slns_pkg::REQ_EDGE ||
                        in_req.req_type == slns_pkg::REQ_PLANE) &&
            CB'(in_req.nearest_index) < count_r && in_req.nearest_sq_dist < thr_r) begin
          state_nxt = slns_pkg::S_CENTRE;
        end
      end
      slns_pkg::S_CENTRE: begin
        if (ph_r == 2'd1) begin
          state_nxt = (CB'(near_r) + 1'b1 < count_r) ? slns_pkg::S_UP
                    : (near_r == '0) ? slns_pkg::S_RESULT : slns_pkg::S_DOWN;
        end
      end
      slns_pkg::S_UP: begin
        if (ph_r == 2'd3 && (up_stop || up_last)) begin
          state_nxt = (near_r == '0) ? slns_pkg::S_RESULT : slns_pkg::S_DOWN;
        end
      end
      slns_pkg::S_DOWN: begin
        if (ph_r == 2'd3 && (dn_stop || dn_last)) begin
          state_nxt = slns_pkg::S_RESULT;
        end
      end
      slns_pkg::S_RESULT: state_nxt = slns_pkg::S_IDLE;
      default: state_nxt = slns_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slns_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovalid_r <= 1'b0;
      ph_r     <= '0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        slns_pkg::S_IDLE: begin
          ph_r <= 2'd0;
          if (in_fire) begin
            req_r   <= in_req.req_type;
            qx_r    <= in_req.pos_x;
            qy_r    <= in_req.pos_y;
            qz_r    <= in_req.pos_z;
            near_r  <= in_req.nearest_index;
            best2_r <= thr_r;
            best3_r <= thr_r;
            got2_r  <= 1'b0;
            got3_r  <= 1'b0;
            ind2_r  <= '0;
            ind3_r  <= '0;
            of_r    <= '0;
            os_r    <= '0;
            ot_r    <= '0;
            ostat_r <= slns_pkg::ST_DONE;
            case (slns_pkg::req_t'(in_req.req_type))
              slns_pkg::REQ_CLEAR: begin
                count_r  <= '0;
                ovalid_r <= 1'b1;
              end
              slns_pkg::REQ_APPEND: begin
                ovalid_r <= 1'b1;
                if (ram_we) begin
                  of_r    <= count_r[IB-1:0];
                  count_r <= count_r + 1'b1;
                end else begin
                  ostat_r <= slns_pkg::ST_FULL;
                end
              end
              default: begin
                if (!(CB'(in_req.nearest_index) < count_r &&
                      in_req.nearest_sq_dist < thr_r)) begin
                  ostat_r  <= slns_pkg::ST_INVALID;
                  ovalid_r <= 1'b1;
                end
              end
            endcase
          end
        end
        slns_pkg::S_CENTRE: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            cl_r <= (LB+2)'(sl);
            ph_r <= 2'd0;
            if (CB'(near_r) + 1'b1 < count_r) begin
              j_r <= CB'(near_r) + 1'b1;
            end else begin
              j_r <= CB'(near_r) - 1'b1;
            end
          end
        end
        slns_pkg::S_UP, slns_pkg::S_DOWN: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 2'd1) begin
            l_r <= (LB+2)'(sl);
          end
          if (ph_r == 2'd3) begin
            if (state_r == slns_pkg::S_UP ? !(up_skip || up_stop)
                                          : !(dn_skip || dn_stop)) begin
              if (to2) begin
                if (SUB'(cand_dist) < SUB'(best2_r)) begin
                  best2_r <= cand_dist[TB-1:0];
                  ind2_r  <= j_r[IB-1:0];
                  got2_r  <= 1'b1;
                end
              end else if (SUB'(cand_dist) < SUB'(best3_r)) begin
                best3_r <= cand_dist[TB-1:0];
                ind3_r  <= j_r[IB-1:0];
                got3_r  <= 1'b1;
              end
            end
            if (state_r == slns_pkg::S_UP) begin
              j_r <= (up_stop || up_last) ? CB'(near_r) - 1'b1 : j_r + 1'b1;
            end else begin
              j_r <= j_r - 1'b1;
            end
          end
        end
        slns_pkg::S_RESULT: begin
          ovalid_r <= 1'b1;
          if (edge_q ? got2_r : (got2_r && got3_r)) begin
            of_r <= near_r;
            os_r <= ind2_r;
            ot_r <= edge_q ? '0 : ind3_r;
          end else begin
            ostat_r <= slns_pkg::ST_MISSING;
          end
        end
        default: ;
      endcase
    end
  end

  // Result channel
  assign out_res.valid        = ovalid_r;
  assign out_res.status       = ostat_r;
  assign out_res.first_index  = of_r;
  assign out_res.second_index = os_r;
  assign out_res.third_index  = ot_r;

endmodule

/* bench/slns_checker.sv */
// ----------------------------------------------------------------------------
// slns_checker
// Watches the request, result and register ports of the neighbour search,
// predicts each result from its own copy of the point store and registers,
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slns_checker
  import slns_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  slns_req_if                   req,
  slns_res_if                   res,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [63:0]           cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t               status;
    logic [IDX_BITS-1:0]   first;
    logic [IDX_BITS-1:0]   second;
    logic [IDX_BITS-1:0]   third;
  } match_t;

  logic signed [COORD_BITS-1:0] pt_x [POINT_DEPTH];
  logic signed [COORD_BITS-1:0] pt_y [POINT_DEPTH];
  logic signed [COORD_BITS-1:0] pt_z [POINT_DEPTH];
  int                           pt_line [POINT_DEPTH];
  int                           pt_count;
  logic [THR_BITS-1:0]          thr;
  int                           span;
  match_t                       awaited [$];

  // squared axis difference, saturated at the difference cap
  function automatic longint unsigned axis_sq(logic signed [COORD_BITS-1:0] a,
                                              logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    if (d > longint'(DIFF_CAP)) d = longint'(DIFF_CAP);
    return longint'(d * d);
  endfunction

  function automatic longint unsigned dist_sq(int j, logic signed [COORD_BITS-1:0] x,
                                              logic signed [COORD_BITS-1:0] y,
                                              logic signed [COORD_BITS-1:0] z);
    return axis_sq(pt_x[j], x) + axis_sq(pt_y[j], y) + axis_sq(pt_z[j], z);
  endfunction

  // apply one request to the store and work out its result
  function automatic match_t correspond(req_t kind, logic signed [COORD_BITS-1:0] x,
                                        logic signed [COORD_BITS-1:0] y,
                                        logic signed [COORD_BITS-1:0] z,
                                        logic [LINE_BITS-1:0] line,
                                        logic [IDX_BITS-1:0] near,
                                        logic [THR_BITS-1:0] near_d);
    match_t m;
    int cl, hi, lo, l, ind2, ind3;
    longint unsigned best2, best3, d;
    bit got2, got3, edge_q;
    m = '{ST_DONE, '0, '0, '0};
    if (kind == REQ_CLEAR) begin
      pt_count = 0;
    end else if (kind == REQ_APPEND) begin
      if (pt_count >= POINT_DEPTH) begin
        m.status = ST_FULL;
      end else begin
        pt_x[pt_count] = x;
        pt_y[pt_count] = y;
        pt_z[pt_count] = z;
        pt_line[pt_count] = (int'(line) >= LINE_COUNT) ? LINE_COUNT - 1 : int'(line);
        m.first = IDX_BITS'(pt_count);
        pt_count++;
      end
    end else if (int'(near) >= pt_count || near_d >= thr) begin
      m.status = ST_INVALID;
    end else begin
      edge_q = (kind == REQ_EDGE);
      cl = pt_line[near];
      hi = cl + span;
      lo = cl - span;
      best2 = thr;
      best3 = thr;
      got2 = 0;
      got3 = 0;
      ind2 = 0;
      ind3 = 0;
      // walk up from the entry after the nearest point
      for (int j = int'(near) + 1; j < pt_count; j++) begin
        l = pt_line[j];
        if (edge_q && l <= cl) continue;
        if (l > hi) break;
        d = dist_sq(j, x, y, z);
        if (edge_q || l <= cl) begin
          if (d < best2) begin best2 = d; ind2 = j; got2 = 1; end
        end else if (d < best3) begin
          best3 = d; ind3 = j; got3 = 1;
        end
      end
      // walk down from the entry before the nearest point
      for (int k = int'(near) - 1; k >= 0; k--) begin
        l = pt_line[k];
        if (edge_q && l >= cl) continue;
        if (l < lo) break;
        d = dist_sq(k, x, y, z);
        if (edge_q || l >= cl) begin
          if (d < best2) begin best2 = d; ind2 = k; got2 = 1; end
        end else if (d < best3) begin
          best3 = d; ind3 = k; got3 = 1;
        end
      end
      if (edge_q ? got2 : (got2 && got3)) begin
        m.first  = near;
        m.second = IDX_BITS'(ind2);
        m.third  = edge_q ? '0 : IDX_BITS'(ind3);
      end else begin
        m.status = ST_MISSING;
      end
    end
    return m;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    match_t want;
    if (!rst_n) begin
      pt_count <= 0;
      thr <= THR_RESET;
      span <= int'(SPAN_RESET);
      awaited.delete();
      fail_count <= 0;
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == 4'(int'(ADDR_THR) * 8)) thr <= cfg_pwdata[THR_BITS-1:0];
        else if (cfg_paddr == 4'(int'(ADDR_SPAN) * 8)) span <= int'(cfg_pwdata[LINE_BITS-1:0]);
      end
      // predict each accepted request
      if (req.valid && req.ready)
        awaited = {awaited, correspond(req_t'(req.req_type), req.pos_x, req.pos_y,
                                       req.pos_z, req.line_id, req.nearest_index,
                                       req.nearest_sq_dist)};
      // compare each accepted result with the oldest prediction
      if (res.valid && res.ready) begin
        if (awaited.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d idx %0d %0d %0d", res.status,
                     res.first_index, res.second_index, res.third_index);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited.pop_front();
          if (res.status !== want.status || res.first_index !== want.first ||
              res.second_index !== want.second || res.third_index !== want.third) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d idx %0d %0d %0d, got %0d idx %0d %0d %0d",
                       want.status, want.first, want.second, want.third, res.status,
                       res.first_index, res.second_index, res.third_index);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives clears, appends and edge/plane queries into the neighbour search
// under several register settings and idling patterns; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import slns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  TARGET    = 1100;
  localparam longint LIMIT  = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          sent = 0;
  int          tx_idle = 20, rx_idle = 67;
  longint      cycles = 0;

  // local view of the store, used to aim queries at stored points
  logic signed [COORD_BITS-1:0] mine_x [POINT_DEPTH];
  logic signed [COORD_BITS-1:0] mine_y [POINT_DEPTH];
  logic signed [COORD_BITS-1:0] mine_z [POINT_DEPTH];
  int mine_count = 0;

  slns_req_if req_ch();
  slns_res_if res_ch();

  scan_line_neighbour_search dut (
    .clk, .rst_n, .in_req(req_ch.sink), .out_res(res_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  slns_checker chk (
    .clk, .rst_n, .req(req_ch), .res(res_ch),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  always #6 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.req_type = REQ_CLEAR;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    req_ch.line_id = '0;
    req_ch.nearest_index = '0;
    req_ch.nearest_sq_dist = '0;
    res_ch.ready = 0;
  end

  // stall the result side at random
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // send one request, idling first at random, and hold it until accepted
  task automatic send(req_t kind, logic signed [COORD_BITS-1:0] x,
                      logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z,
                      logic [LINE_BITS-1:0] line, logic [IDX_BITS-1:0] near,
                      logic [THR_BITS-1:0] near_d);
    bit ok;
    while ($urandom_range(99) < tx_idle) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.req_type <= kind;
    req_ch.pos_x <= x;
    req_ch.pos_y <= y;
    req_ch.pos_z <= z;
    req_ch.line_id <= line;
    req_ch.nearest_index <= near;
    req_ch.nearest_sq_dist <= near_d;
    do begin
      @(negedge clk);
      ok = req_ch.ready;
      @(posedge clk);
    end while (!ok);
    sent++;
    if (kind == REQ_CLEAR) mine_count = 0;
    else if (kind == REQ_APPEND && mine_count < POINT_DEPTH) begin
      mine_x[mine_count] = x;
      mine_y[mine_count] = y;
      mine_z[mine_count] = z;
      mine_count++;
    end
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both registers; the block is idle here
  task automatic configure(logic [THR_BITS-1:0] t, logic [LINE_BITS-1:0] s);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 4'(int'(ADDR_THR) * 8); cfg_pwdata <= 64'(t);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_penable <= 0;
    cfg_paddr <= 4'(int'(ADDR_SPAN) * 8); cfg_pwdata <= 64'(s);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] jitter(logic signed [COORD_BITS-1:0] c,
                                                          int r);
    return c + COORD_BITS'($signed($urandom_range(2 * r)) - r);
  endfunction

  function automatic logic [THR_BITS-1:0] any40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // query aimed at a stored point, mostly well formed
  task automatic aim_query();
    int k;
    logic [IDX_BITS-1:0] near;
    logic [THR_BITS-1:0] nd;
    req_t kind;
    kind = $urandom_range(1) ? REQ_EDGE : REQ_PLANE;
    k = (mine_count > 0) ? $urandom_range(mine_count - 1) : 0;
    near = ($urandom_range(9) == 0 || mine_count == 0) ? IDX_BITS'($urandom) : IDX_BITS'(k);
    nd = ($urandom_range(9) == 0) ? any40() : THR_BITS'($urandom_range(1 << 24));
    if (mine_count > 0)
      send(kind, jitter(mine_x[k], 1200), jitter(mine_y[k], 1200), jitter(mine_z[k], 1200),
           LINE_BITS'($urandom), near, nd);
    else
      send(kind, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
           LINE_BITS'($urandom), near, nd);
  endtask

  initial begin
    logic signed [COORD_BITS-1:0] bx, by, bz;
    int line, n, batch;
    logic [THR_BITS-1:0] thr_set [4];
    logic [LINE_BITS-1:0] span_set [4];
    thr_set = '{THR_RESET, '0, '1, 40'd4000000};
    span_set = '{SPAN_RESET, '0, '1, 6'd1};

    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: neighbours, ties, walk below line zero, invalid and missing cases
    send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    send(REQ_APPEND, 0, 0, 0, 0, 0, 0);
    send(REQ_APPEND, 1024, 0, 0, 1, 0, 0);
    send(REQ_APPEND, -1024, 0, 0, 1, 0, 0);
    send(REQ_APPEND, 0, 1024, 0, 2, 0, 0);
    send(REQ_APPEND, 0, -1024, 0, 3, 0, 0);
    send(REQ_APPEND, -24'sd8388608, 24'sd8388607, -24'sd8388608, '1, 0, 0);
    send(REQ_EDGE, 0, 0, 0, '1, 1, 0);
    send(REQ_PLANE, 0, 0, 0, 0, 2, 100);
    send(REQ_EDGE, 0, 0, 0, 0, 0, 0);
    send(REQ_PLANE, 0, 0, 0, 0, 0, 0);
    send(REQ_EDGE, 24'sd8388607, -24'sd8388608, 24'sd8388607, 0, 3, 0);
    send(REQ_PLANE, 0, 0, 0, 0, '1, 0);
    send(REQ_EDGE, 0, 0, 0, 0, 1, '1);
    send(REQ_EDGE, 0, 0, 0, 0, 1, THR_RESET);
    send(REQ_PLANE, 0, 0, 0, 0, 5, 0);
    send(REQ_PLANE, 0, 0, 0, 0, 6, 0);
    send(REQ_EDGE, 0, 0, 0, 0, 6, 0);
    drain();

    // random: short scan-ordered stores with queries around them
    batch = 0;
    while (sent < TARGET) begin
      if (sent < TARGET / 3) begin tx_idle = 20; rx_idle = 67; end
      else if (sent < 2 * TARGET / 3) begin tx_idle = 67; rx_idle = 20; end
      else begin tx_idle = 0; rx_idle = 0; end
      if (batch % 4 == 0) begin
        drain();
        if (batch % 16 == 12) configure(any40(), LINE_BITS'($urandom));
        else configure(thr_set[(batch / 4) % 4], span_set[(batch / 16) % 4]);
      end
      batch++;
      if ($urandom_range(4) != 0) send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      bx = COORD_BITS'($signed($urandom_range(200000)) - 100000);
      by = COORD_BITS'($signed($urandom_range(200000)) - 100000);
      bz = COORD_BITS'($signed($urandom_range(20000)) - 10000);
      line = $urandom_range(63);
      n = $urandom_range(3, 30);
      for (int i = 0; i < n && mine_count < 60; i++) begin
        if ($urandom_range(19) == 0)
          send(REQ_APPEND, COORD_BITS'($urandom), COORD_BITS'($urandom),
               COORD_BITS'($urandom), LINE_BITS'($urandom), IDX_BITS'($urandom), any40());
        else begin
          if ($urandom_range(3) == 0 && line < 63) line++;
          send(REQ_APPEND, jitter(bx, 1500), jitter(by, 1500), jitter(bz, 1500),
               LINE_BITS'(line), IDX_BITS'($urandom), any40());
        end
      end
      n = $urandom_range(5, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0)
          send(req_t'($urandom_range(3)), COORD_BITS'($urandom), COORD_BITS'($urandom),
               COORD_BITS'($urandom), LINE_BITS'($urandom), IDX_BITS'($urandom % 64),
               any40());
        else
          aim_query();
      end
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
